FILE: hdl/set_assoc_cache_tag_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag controller
// Concurrent checks on clk, disabled while rst_n is low; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH

`ifndef SYNTH
// property must hold at every edge out of reset
`define SAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// expression must never be true out of reset
`define SAC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define SAC_ASSERT(lbl, prop, msg)
`define SAC_NEVER(lbl, expr, msg)
`endif

`endif

FILE: hdl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared geometry constants, codes, row layout and address helpers.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int ADDR_W     = 32;
    localparam int OPC_W      = 2;
    localparam int MAX_WAYS   = 8;
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int MAX_SETS   = 256;
    localparam int SET_W      = $clog2(MAX_SETS);
    localparam int TAG_W      = ADDR_W;
    localparam int PLRU_W     = MAX_WAYS - 1;
    localparam int PLRU_IDX_W = $clog2(PLRU_W);
    localparam int LVL_W      = $clog2(WAY_W);
    localparam int LFSR_W     = 16;
    localparam int SHAMT_W    = 5;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // access kinds; the spare code is handled like a load
    localparam logic [OPC_W-1:0] OPC_STORE = 2'd0;
    localparam logic [OPC_W-1:0] OPC_LOAD  = 2'd1;
    localparam logic [OPC_W-1:0] OPC_FETCH = 2'd2;
    localparam logic [OPC_W-1:0] OPC_SPARE = 2'd3;

    // replacement policy codes; the spare code acts as tree PLRU
    localparam logic [1:0] POL_PLRU   = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;
    localparam logic [1:0] POL_SPARE  = 2'd3;

    // register map (word index)
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WAYS_LOG2   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_POLICY      = 2'd3;

    typedef struct packed {
        logic [3:0] offset_bits;
        logic [3:0] index_bits;
        logic [1:0] ways_log2;
        logic [1:0] replace_policy;
    } cfg_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             valid;
        logic             dirty;
    } way_entry_t;

    // one RAM row holds a whole set
    typedef struct packed {
        way_entry_t [MAX_WAYS-1:0] ways;
        logic [PLRU_W-1:0]         plru;
        logic [WAY_W-1:0]          fifo;
    } set_row_t;

    localparam int ROW_W = $bits(set_row_t);

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             writeback;
        logic             lfsr_step;
    } lkp_res_t;

    function automatic logic [3:0] index_clamp(cfg_t c);
        return (c.index_bits > 4'(SET_W)) ? 4'(SET_W) : c.index_bits;
    endfunction

    function automatic logic [SET_W-1:0] set_of(logic [ADDR_W-1:0] addr, cfg_t c);
        logic [ADDR_W-1:0] shifted;
        logic [SET_W-1:0]  ones;
        shifted = addr >> c.offset_bits;
        ones    = '1;
        return shifted[SET_W-1:0] & ~(ones << index_clamp(c));
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(logic [ADDR_W-1:0] addr, cfg_t c);
        logic [SHAMT_W-1:0] shamt;
        shamt = SHAMT_W'(c.offset_bits) + SHAMT_W'(index_clamp(c));
        return TAG_W'(addr >> shamt);
    endfunction

    function automatic logic [WAY_W-1:0] way_mask(cfg_t c);
        logic [WAY_W-1:0] ones;
        ones = '1;
        return ~(ones << c.ways_log2);
    endfunction

endpackage

FILE: hdl/sac_if.sv
// ----------------------------------------------------------------------------
// sac_req_if / sac_rsp_if
// Valid/ready channels for access requests and lookup responses.
// ----------------------------------------------------------------------------
interface sac_req_if import sac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic [OPC_W-1:0]  opcode;

    modport source (output valid, address, opcode, input ready);
    modport sink   (input valid, address, opcode, output ready);
endinterface

interface sac_rsp_if import sac_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             writeback;

    modport source (output valid, hit, way, writeback, input ready);
    modport sink   (input valid, hit, way, writeback, output ready);
endinterface

FILE: hdl/sac_apb_regs.sv
// ----------------------------------------------------------------------------
// sac_apb_regs
// APB configuration registers: offset bits, index bits, ways, policy.
// ----------------------------------------------------------------------------
module sac_apb_regs import sac_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_OFFSET_BITS: cfg_next.offset_bits    = pwdata[3:0];
                REG_INDEX_BITS:  cfg_next.index_bits     = pwdata[3:0];
                REG_WAYS_LOG2:   cfg_next.ways_log2      = pwdata[1:0];
                REG_POLICY:      cfg_next.replace_policy = pwdata[1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_OFFSET_BITS: prdata = APB_DATA_W'(cfg_reg.offset_bits);
            REG_INDEX_BITS:  prdata = APB_DATA_W'(cfg_reg.index_bits);
            REG_WAYS_LOG2:   prdata = APB_DATA_W'(cfg_reg.ways_log2);
            REG_POLICY:      prdata = APB_DATA_W'(cfg_reg.replace_policy);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits    <= 4'd5;
            cfg_reg.index_bits     <= 4'd0;
            cfg_reg.ways_log2      <= 2'd0;
            cfg_reg.replace_policy <= POL_PLRU;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/sac_row_ram.sv
// ----------------------------------------------------------------------------
// sac_row_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sac_row_ram #(
    parameter int DATA_W = 8,
    parameter int RAM_AW = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [RAM_AW-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [RAM_AW-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1 << RAM_AW) - 1];
    logic [DATA_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/sac_lookup.sv
// ----------------------------------------------------------------------------
// sac_lookup
// Way compare, victim choice and row update for one access.
// ----------------------------------------------------------------------------
module sac_lookup import sac_pkg::*; (
    input  cfg_t              cfg,
    input  logic [ADDR_W-1:0] address,
    input  logic [OPC_W-1:0]  opcode,
    input  set_row_t          row_in,
    input  logic [LFSR_W-1:0] lfsr_adv,
    output set_row_t          row_out,
    output lkp_res_t          res
);

    logic [TAG_W-1:0]      tag;
    logic [WAY_W-1:0]      wmask;
    logic                  is_store;
    logic                  use_plru;
    logic [MAX_WAYS-1:0]   match;
    logic                  hit;
    logic [WAY_W-1:0]      hway;
    logic [WAY_W-1:0]      vway;
    logic [WAY_W-1:0]      fifo_way;
    logic [WAY_W-1:0]      miss_way;
    logic [PLRU_W-1:0]     plru_touched;
    logic [PLRU_W-1:0]     plru_evict;
    logic [PLRU_IDX_W-1:0] t_node;
    logic [PLRU_IDX_W-1:0] v_node;
    logic                  t_dir;
    logic                  v_bit;

    assign tag      = tag_of(address, cfg);
    assign wmask    = way_mask(cfg);
    assign is_store = (opcode == OPC_STORE);
    assign use_plru = (cfg.replace_policy == POL_PLRU) || (cfg.replace_policy == POL_SPARE);
    assign fifo_way = row_in.fifo & wmask;

    // compare only ways in use; lowest matching way wins
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            match[w] = row_in.ways[w].valid && (row_in.ways[w].tag == tag)
                       && ((WAY_W'(w) & ~wmask) == '0);
        end
        hit  = |match;
        hway = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hway = WAY_W'(w);
            end
        end
    end

    // hit: point every node on the path away from the hit way
    always_comb
    begin
        plru_touched = row_in.plru;
        t_node       = '0;
        t_dir        = 1'b0;
        for (int i = 0; i < WAY_W; i++)
        begin
            if (i < int'(cfg.ways_log2))
            begin
                t_dir                = hway[LVL_W'(int'(cfg.ways_log2) - 1 - i)];
                plru_touched[t_node] = ~t_dir;
                t_node               = PLRU_IDX_W'(2 * int'(t_node) + 1 + int'(t_dir));
            end
        end
    end

    // miss: follow node bits to the victim, flipping each one passed
    always_comb
    begin
        plru_evict = row_in.plru;
        v_node     = '0;
        v_bit      = 1'b0;
        vway       = '0;
        for (int i = 0; i < WAY_W; i++)
        begin
            if (i < int'(cfg.ways_log2))
            begin
                v_bit              = plru_evict[v_node];
                plru_evict[v_node] = ~v_bit;
                v_node             = PLRU_IDX_W'(2 * int'(v_node) + 1 + int'(v_bit));
                vway               = WAY_W'({vway, v_bit});
            end
        end
    end

    always_comb
    begin
        case (cfg.replace_policy)
            POL_FIFO:   miss_way = fifo_way;
            POL_RANDOM: miss_way = lfsr_adv[WAY_W-1:0] & wmask;
            default:    miss_way = vway & wmask;
        endcase
    end

    always_comb
    begin
        row_out       = row_in;
        res.hit       = hit;
        res.way       = hway;
        res.writeback = 1'b0;
        res.lfsr_step = 1'b0;
        if (hit)
        begin
            if (is_store)
            begin
                row_out.ways[hway].dirty = 1'b1;
            end
            if (use_plru)
            begin
                row_out.plru = plru_touched;
            end
        end
        else
        begin
            res.way                  = miss_way;
            res.writeback            = row_in.ways[miss_way].valid
                                       & row_in.ways[miss_way].dirty;
            row_out.ways[miss_way].tag   = tag;
            row_out.ways[miss_way].valid = 1'b1;
            row_out.ways[miss_way].dirty = is_store;
            if (use_plru)
            begin
                row_out.plru = plru_evict;
            end
            if (cfg.replace_policy == POL_FIFO)
            begin
                row_out.fifo = (fifo_way + WAY_W'(1)) & wmask;
            end
            if (cfg.replace_policy == POL_RANDOM)
            begin
                res.lfsr_step = 1'b1;
            end
        end
    end

endmodule

FILE: hdl/set_assoc_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Tag/replacement controller: lookup, tree-PLRU/FIFO/random victim, refill.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | beat contents
//  --------+-----+---------------+-------------------------------
//  req     | in  | valid/ready   | address[31:0], opcode[1:0]
//  rsp     | out | valid/ready   | hit, way[2:0], writeback
//  apb     | in  | psel/penable  | paddr[3:0], pwdata, prdata
//
//  One beat per cycle sustained while rsp is not stalled; an accepted beat
//  waits in the lookup stage, then loads the result register and rsp.valid.
//  The set row RAM (one read, one write port) is read at accept; the
//  compare/update runs on the registered row and writes it back as the
//  result register loads. A one-entry forward register covers a back-to-back
//  access to the same set. No clearing pass: per-set row-valid flops, cleared
//  by rst_n, make an unwritten row read as zero. A stalled rsp holds the
//  lookup stage, which in turn holds req.ready low.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_controller_macros.svh"

module set_assoc_cache_tag_controller import sac_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    sac_req_if.sink               req,
    sac_rsp_if.source             rsp
);

    cfg_t cfg;

    // handshake / pipeline control
    logic accept;
    logic s1_fire;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    // lookup stage payload
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [OPC_W-1:0]  s1_opc_reg;
    logic [SET_W-1:0]  s1_set_reg;
    logic [SET_W-1:0]  rd_set;

    // set rows
    set_row_t          ram_rd_row;
    set_row_t          row_in;
    set_row_t          row_out;
    logic [MAX_SETS-1:0] row_valid_reg;
    logic [MAX_SETS-1:0] row_valid_next;

    // last row written, for same-set back-to-back accesses
    logic             fwd_valid_reg;
    logic [SET_W-1:0] fwd_set_reg;
    set_row_t         fwd_row_reg;

    lkp_res_t          res;
    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;
    logic [LFSR_W-1:0] lfsr_adv;

    // result register
    logic             rsp_hit_reg;
    logic [WAY_W-1:0] rsp_way_reg;
    logic             rsp_wb_reg;

    sac_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // lookup stage advances when the result register is free or draining
    assign s1_fire   = s1_valid_reg & (~rsp_valid_reg | rsp.ready);
    assign req.ready = ~s1_valid_reg | s1_fire;
    assign accept    = req.valid & req.ready;
    assign rd_set    = set_of(req.address, cfg);

    sac_row_ram #(
        .DATA_W (ROW_W),
        .RAM_AW (SET_W)
    ) u_rows (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_set_reg),
        .wr_data (row_out),
        .rd_en   (accept),
        .rd_addr (rd_set),
        .rd_data (ram_rd_row)
    );

    // forward beats RAM; a never-written set reads as all zero
    always_comb
    begin
        if (fwd_valid_reg && (fwd_set_reg == s1_set_reg))
        begin
            row_in = fwd_row_reg;
        end
        else if (row_valid_reg[s1_set_reg])
        begin
            row_in = ram_rd_row;
        end
        else
        begin
            row_in = '0;
        end
    end

    // x^16+x^14+x^13+x^11+1, shift right, feedback into the top bit
    assign lfsr_adv = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                       lfsr_reg[LFSR_W-1:1]};

    sac_lookup u_lookup (
        .cfg      (cfg),
        .address  (s1_addr_reg),
        .opcode   (s1_opc_reg),
        .row_in   (row_in),
        .lfsr_adv (lfsr_adv),
        .row_out  (row_out),
        .res      (res)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        row_valid_next = row_valid_reg;
        lfsr_next      = lfsr_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (s1_fire)
        begin
            s1_valid_next              = 1'b0;
            rsp_valid_next             = 1'b1;
            row_valid_next[s1_set_reg] = 1'b1;
            if (res.lfsr_step)
            begin
                lfsr_next = lfsr_adv;
            end
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            row_valid_reg <= row_valid_next;
            lfsr_reg      <= lfsr_next;
            if (s1_fire)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= req.address;
            s1_opc_reg  <= req.opcode;
            s1_set_reg  <= rd_set;
        end
        if (s1_fire)
        begin
            fwd_set_reg <= s1_set_reg;
            fwd_row_reg <= row_out;
            rsp_hit_reg <= res.hit;
            rsp_way_reg <= res.way;
            rsp_wb_reg  <= res.writeback;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.hit       = rsp_hit_reg;
    assign rsp.way       = rsp_way_reg;
    assign rsp.writeback = rsp_wb_reg;

    // every written row is marked valid and captured for forwarding
    `SAC_ASSERT(a_fwd_after_write, s1_fire |=> fwd_valid_reg && row_valid_reg[fwd_set_reg], "forward entry missing after row write")
    // a hit never evicts
    `SAC_ASSERT(a_hit_no_wb, rsp_valid_reg && rsp_hit_reg |-> !rsp_wb_reg, "writeback flagged on a hit")
    // a held lookup keeps its set
    `SAC_ASSERT(a_s1_hold, s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_set_reg), "lookup stage lost its beat")
    `SAC_NEVER(a_lfsr_nonzero, lfsr_reg == '0, "LFSR locked at zero")

endmodule
